@@ rtl/core/sqh_pkg.sv @@
// sqh_pkg: shared types and constants for the stack/queue hybrid store.
// Used by sqh_cell, sqh_out_buf and stack_queue_hybrid. No dependencies.
package sqh_pkg;

  localparam int unsigned CapacityDef = 1024;
  localparam int unsigned WordW       = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_TOP    = 2'd0,
    CMD_PUSH_BOTTOM = 2'd1,
    CMD_POP         = 2'd2,
    CMD_CLEAR       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Per-cycle control for every cell; the shifts are shared by all cells, load is per cell.
  typedef struct packed {
    logic shift_dn;  // push on top: each cell takes its upper neighbor
    logic shift_up;  // pop: each cell takes its lower neighbor
    logic load;      // push at bottom: this cell takes the input word
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [WordW-1:0] popped;
    status_e                 status;
    logic                    empty;
  } result_t;

endpackage

@@ rtl/core/sqh_cell.sv @@
// sqh_cell: one word slot of the shift chain.
// Depends on sqh_pkg.
module sqh_cell (
  input  logic                       clk_i,
  input  sqh_pkg::cell_ctrl_t        ctrl_i,
  input  logic [sqh_pkg::WordW-1:0]  above_i,  // neighbor toward the top
  input  logic [sqh_pkg::WordW-1:0]  below_i,  // neighbor toward the bottom
  input  logic [sqh_pkg::WordW-1:0]  word_i,   // word pushed at the bottom
  output logic [sqh_pkg::WordW-1:0]  data_o
);
  import sqh_pkg::*;

  logic [WordW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    priority if (ctrl_i.shift_dn) begin
      data_q <= above_i;
    end else if (ctrl_i.shift_up) begin
      data_q <= below_i;
    end else if (ctrl_i.load) begin
      data_q <= word_i;
    end else begin
      data_q <= data_q;
    end
  end

  assign data_o = data_q;

endmodule

@@ rtl/core/sqh_out_buf.sv @@
// sqh_out_buf: result register plus skid slot on the output channel.
// Depends on sqh_pkg.
module sqh_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sqh_pkg::result_t res_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sqh_pkg::result_t res_o
);
  import sqh_pkg::*;

  logic    main_vld_q, main_vld_d;
  logic    skid_vld_q, skid_vld_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    take;

  assign take = main_vld_q && !out_stall_i;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (!main_vld_q || take) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        main_vld_d = 1'b1;
        skid_d     = res_i;
        skid_vld_d = push_i;
      end else begin
        main_d     = res_i;
        main_vld_d = push_i;
      end
    end else if (push_i) begin
      skid_d     = res_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign res_o       = main_q;

`ifndef SYNTHESIS
  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q)
    else $error("skid slot holds a beat while result register is empty");
  a_take_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && skid_vld_q) |=> main_vld_q)
    else $error("skid beat lost when result register was taken");
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !skid_vld_q) |=> main_vld_q)
    else $error("accepted beat did not reach the output");
`endif

endmodule

@@ rtl/core/stack_queue_hybrid.sv @@
// stack_queue_hybrid: bounded deque of signed words, push at either end, pop at top.
// Depends on sqh_pkg, sqh_cell and sqh_out_buf.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command beat:
//   command_i (0 push top, 1 push bottom, 2 pop, 3 clear) and value_i.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   beat per command: popped_value_o, status_o (0 ok, 1 overflow,
//   2 underflow) and is_empty_o.
//   The store is a chain of CAPACITY cells, cell 0 holding the top word.
//   Push top shifts the whole chain one cell down, pop shifts it one cell
//   up, push bottom writes the cell just below the last held word.
//   The result is registered in the output buffer (result register or skid slot).
//   One command per cycle is accepted while in_stall_o is low.
//   Reset clears the word count and the output buffer; cell contents are
//   left as they are and are never read before being written.
//   When the receiver stalls, up to two results wait in the output buffer
//   (result register plus skid slot); in_stall_o rises only when both
//   are occupied, and drops as soon as the receiver takes a beat.
module stack_queue_hybrid #(
  parameter int unsigned CAPACITY = sqh_pkg::CapacityDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       command_i,
  input  logic signed [sqh_pkg::WordW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [sqh_pkg::WordW-1:0] popped_value_o,
  output logic [1:0]                       status_o,
  output logic                             is_empty_o
);
  import sqh_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]  count_q, count_d;
  logic             accept;
  cmd_e             cmd;
  logic             full, empty;
  logic             do_push_top, do_push_bot, do_pop;
  result_t          res;
  result_t          res_out;
  logic             buf_full;
  logic [WordW-1:0] cell_data [CAPACITY];

  assign accept = in_valid_i && !buf_full;
  assign cmd    = cmd_e'(command_i);
  assign full   = (count_q == CntW'(CAPACITY));
  assign empty  = (count_q == '0);

  // Command decode and word count update.
  always_comb begin
    do_push_top = 1'b0;
    do_push_bot = 1'b0;
    do_pop      = 1'b0;
    count_d     = count_q;
    res.popped  = '0;
    res.status  = ST_OK;
    unique case (cmd)
      CMD_PUSH_TOP: begin
        if (full) begin
          res.status = ST_OVERFLOW;
        end else begin
          do_push_top = accept;
          count_d     = count_q + CntW'(1);
        end
      end
      CMD_PUSH_BOTTOM: begin
        if (full) begin
          res.status = ST_OVERFLOW;
        end else begin
          do_push_bot = accept;
          count_d     = count_q + CntW'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          res.status = ST_UNDERFLOW;
        end else begin
          do_pop     = accept;
          count_d    = count_q - CntW'(1);
          res.popped = cell_data[0];
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    res.empty = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // The cell chain: top at index 0, bottom word at index count_q-1.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctrl_t       ctrl;
    logic [WordW-1:0] above, below;

    assign ctrl.shift_dn = do_push_top;
    assign ctrl.shift_up = do_pop;
    assign ctrl.load     = do_push_bot && (count_q == CntW'(i));

    if (i == 0) begin : g_top
      assign above = value_i;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_bot
      assign below = cell_data[i];
    end else begin : g_up
      assign below = cell_data[i+1];
    end

    sqh_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .above_i (above),
      .below_i (below),
      .word_i  (value_i),
      .data_o  (cell_data[i])
    );
  end

  sqh_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign in_stall_o     = buf_full;
  assign popped_value_o = res_out.popped;
  assign status_o       = res_out.status;
  assign is_empty_o     = res_out.empty;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("word count exceeds capacity");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == CMD_CLEAR) |=> (count_q == '0))
    else $error("clear did not empty the store");
  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !full && (cmd == CMD_PUSH_TOP || cmd == CMD_PUSH_BOTTOM))
    |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("push did not add one word");
  a_one_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({do_push_top, do_push_bot, do_pop}) <= 1)
    else $error("conflicting chain operations in one cycle");
`endif

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for stack_queue_hybrid, built around a circular-buffer deque predictor.
// Random valid and stall gaps are applied on both channels.
// Depends on sqh_pkg and the stack_queue_hybrid RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sqh_pkg::*;

  localparam int unsigned Depth    = CapacityDef;
  localparam int unsigned MaxWait  = 17;
  // Watchdog limit, set well above the slowest legal run; keep a wide margin.
  localparam int unsigned RunLimit = 400000;

  localparam logic signed [WordW-1:0] WordMin = {1'b1, {(WordW-1){1'b0}}};
  localparam logic signed [WordW-1:0] WordMax = {1'b0, {(WordW-1){1'b1}}};

  // One command beat as issued on the input channel.
  typedef struct packed {
    cmd_e                    cmd;
    logic signed [WordW-1:0] value;
  } cmd_beat_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              command_i   = CMD_PUSH_TOP;
  logic signed [WordW-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [WordW-1:0] popped_value_o;
  logic [1:0]              status_o;
  logic                    is_empty_o;

  stack_queue_hybrid #(
    .CAPACITY(Depth)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .popped_value_o(popped_value_o),
    .status_o      (status_o),
    .is_empty_o    (is_empty_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Deque predictor: circular buffer located by a bottom slot and a word count.
  // Depth d from the bottom lives at slot (deque_base + d) mod Depth.
  // ---------------------------------------------------------------------------
  logic signed [WordW-1:0] deque_mem [Depth];
  int unsigned             deque_base = 0;
  int unsigned             deque_fill = 0;

  result_t                 expected_q[$];   // results owed by the block, oldest first
  cmd_beat_t               cmd_q[$];        // command beats not yet issued
  cmd_beat_t               issue_beat;
  result_t                 want;

  int unsigned             plan_fill = 0;   // word count as seen while planning stimulus
  int unsigned             error_cnt = 0;
  int unsigned             cycles_run = 0;
  bit                      in_taken = 1'b0;
  bit                      out_taken = 1'b0;
  bit                      in_steady = 1'b0;
  bit                      out_steady = 1'b0;
  int unsigned             in_wait = 0;
  int unsigned             out_wait = 0;

  function automatic result_t deque_step(cmd_beat_t b);
    result_t r;
    r.popped = '0;
    r.status = ST_OK;
    case (b.cmd)
      CMD_PUSH_TOP: begin
        if (deque_fill >= Depth) begin
          r.status = ST_OVERFLOW;
        end else begin
          deque_mem[(deque_base + deque_fill) % Depth] = b.value;
          deque_fill++;
        end
      end
      CMD_PUSH_BOTTOM: begin
        if (deque_fill >= Depth) begin
          r.status = ST_OVERFLOW;
        end else begin
          deque_base = (deque_base + Depth - 1) % Depth;
          deque_mem[deque_base] = b.value;
          deque_fill++;
        end
      end
      CMD_POP: begin
        if (deque_fill == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          deque_fill--;
          r.popped = deque_mem[(deque_base + deque_fill) % Depth];
        end
      end
      default: begin  // clear, status ok even when already empty
        deque_fill = 0;
        deque_base = 0;
      end
    endcase
    r.empty = (deque_fill == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning. plan_fill tracks only the word count, so that fill and
  // drain sequences can aim at the full and empty corners.
  // ---------------------------------------------------------------------------
  function automatic void plan(cmd_e c, logic signed [WordW-1:0] v);
    cmd_q.push_back(cmd_beat_t'{cmd: c, value: v});
    case (c)
      CMD_PUSH_TOP, CMD_PUSH_BOTTOM: if (plan_fill < Depth) plan_fill++;
      CMD_POP:                       if (plan_fill != 0) plan_fill--;
      default:                       plan_fill = 0;
    endcase
  endfunction

  // Full-range random words half the time, else WordMin, WordMax, zero or -1.
  function automatic logic signed [WordW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return WordMin;
      1:       return WordMax;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_e any_push();
    return ($urandom_range(0, 1) != 0) ? CMD_PUSH_BOTTOM : CMD_PUSH_TOP;
  endfunction

  function automatic cmd_e noise_cmd(int unsigned pop_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return CMD_CLEAR;
    if (roll < 4 + pop_pct) return CMD_POP;
    return any_push();
  endfunction

  // Per-beat pause; a steady stretch runs with no idling at all.
  function automatic int unsigned pause_len(bit steady);
    return steady ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: changes on the falling edge, holds a stalled beat unchanged.
  // in_taken reflects the handshake seen at the preceding rising edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_wait != 0) begin
        in_valid_i <= 1'b0;
        in_wait--;
      end else if (cmd_q.size() != 0) begin
        issue_beat = cmd_q.pop_front();
        command_i  <= issue_beat.cmd;
        value_i    <= issue_beat.value;
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 40) == 0) in_steady = !in_steady;
        in_wait = pause_len(in_steady);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: after each taken result beat, stalls for a random pause drawn by pause_len.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 40) == 0) out_steady = !out_steady;
        out_wait = pause_len(out_steady);
      end
      if (out_wait != 0) begin
        out_stall_i <= 1'b1;
        out_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both handshakes at the rising edge. The result side is
  // checked before a new command is predicted, so a beat never meets its own
  // expectation in the same cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles_run++;
      out_taken = out_valid_o && !out_stall_i;
      in_taken  = in_valid_i && !in_stall_o;
      if (out_taken) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no command outstanding");
          error_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (popped_value_o !== want.popped) begin
            $error("popped_value: expected %0d, actual %0d", want.popped, popped_value_o);
            error_cnt++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            error_cnt++;
          end
          if (is_empty_o !== want.empty) begin
            $error("is_empty: expected %0d, actual %0d", want.empty, is_empty_o);
            error_cnt++;
          end
        end
      end
      if (in_taken) begin
        expected_q.push_back(deque_step(cmd_beat_t'{cmd: cmd_e'(command_i), value: value_i}));
      end
    end
  end

  // Watchdog on the cycle counter.
  initial begin
    wait (cycles_run >= RunLimit);
    $display("simulation failed");
    $finish;
  end

  initial begin
    // Directed: extremes at both ends, pop order, underflow, clear on empty,
    // clear with words held, bottom index wrapping below slot 0.
    plan(CMD_PUSH_TOP,    WordMin);
    plan(CMD_PUSH_BOTTOM, WordMax);
    plan(CMD_PUSH_TOP,    '0);
    plan(CMD_PUSH_BOTTOM, '1);
    repeat (4) plan(CMD_POP, rand_word());
    plan(CMD_POP,         rand_word());        // pop of empty store
    plan(CMD_CLEAR,       rand_word());        // clear when already empty
    plan(CMD_PUSH_TOP,    32'sh5555_5555);
    plan(CMD_PUSH_BOTTOM, 32'shAAAA_AAAA);
    plan(CMD_CLEAR,       '1);
    plan(CMD_POP,         WordMax);            // underflow right after clear
    plan(CMD_PUSH_BOTTOM, rand_word());
    plan(CMD_PUSH_TOP,    rand_word());
    plan(CMD_POP,         rand_word());
    plan(CMD_POP,         rand_word());

    // Random mix at shallow depth.
    repeat (250) plan(noise_cmd(40), rand_word());

    // Fill to capacity, then push into the full store from both ends.
    while (plan_fill < Depth) begin
      plan(($urandom_range(0, 15) == 0) ? CMD_POP : any_push(), rand_word());
    end
    repeat (4) plan(any_push(), rand_word());
    plan(CMD_POP, rand_word());
    plan(CMD_PUSH_BOTTOM, rand_word());
    plan(CMD_PUSH_TOP, rand_word());

    // Drain part way, drop the rest with a clear, then pop-heavy noise.
    repeat (300) plan(($urandom_range(0, 3) == 0) ? any_push() : CMD_POP, rand_word());
    plan(CMD_CLEAR, rand_word());
    repeat (150) plan(noise_cmd(50), rand_word());

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sqh_pkg.sv
rtl/core/sqh_cell.sv
rtl/core/sqh_out_buf.sv
rtl/core/stack_queue_hybrid.sv
tb/tb.sv
